/* design/stbs_pkg.sv */
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int REQ_W       = 2;
  localparam int POS_W       = 11;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  typedef struct packed {
    logic clear;
    logic append;
    logic load_key;
    logic rd_mid;
    logic rd_lo;
    logic step;
    logic set_found;
    logic load_out;
  } stbs_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic out_free;
  } stbs_status_t;

endpackage

/* design/stbs_ctrl.sv */
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [stbs_pkg::REQ_W-1:0] req_type,
  input  stbs_pkg::stbs_status_t    status,
  output stbs_pkg::stbs_cmd_t       cmd
);
  import stbs_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_PROBE     = 3'd1;
  localparam logic [2:0] ST_PROBE_CMP = 3'd2;
  localparam logic [2:0] ST_FIN_CMP   = 3'd3;
  localparam logic [2:0] ST_HOLD      = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (req_type)
            REQ_CLEAR:  cmd.clear = 1'b1;
            REQ_APPEND: cmd.append = 1'b1;
            REQ_SEARCH: begin
              cmd.load_key = 1'b1;
              state_next   = ST_PROBE;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (status.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = ST_PROBE_CMP;
        end else begin
          cmd.rd_lo  = 1'b1;
          state_next = ST_FIN_CMP;
        end
      end
      ST_PROBE_CMP: begin
        cmd.step   = 1'b1;
        state_next = ST_PROBE;
      end
      ST_FIN_CMP: begin
        cmd.set_found = 1'b1;
        state_next    = ST_HOLD;
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/stbs_datapath.sv */
`timescale 1ns / 1ps

module stbs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  stbs_pkg::stbs_cmd_t                cmd,
  output stbs_pkg::stbs_status_t             status,
  input  logic signed [stbs_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [stbs_pkg::POS_W-1:0]         position
);
  import stbs_pkg::*;

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] key;
  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        lo;
  logic [COUNT_W-1:0]        hi;
  logic [COUNT_W-1:0]        mid;
  logic [COUNT_W-1:0]        mid_next;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      hit;
  logic                      full;

  assign full     = (count == COUNT_W'(TABLE_DEPTH));
  assign mid_next = lo + ((hi - lo) >> 1);
  assign rd_addr  = cmd.rd_mid ? mid_next[ADDR_W-1:0] : lo[ADDR_W-1:0];

  assign status.lo_lt_hi = (lo < hi);
  assign status.out_free = !out_valid || out_ready;

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count[ADDR_W-1:0]] <= value;
    end
    if (cmd.rd_mid || cmd.rd_lo) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && !full) begin
      count <= count + COUNT_W'(1);
    end
  end

  // bisection bounds
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= value;
      lo  <= '0;
      hi  <= count;
    end else if (cmd.step) begin
      if (rdata < key) begin
        lo <= mid + COUNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.rd_mid) begin
      mid <= mid_next;
    end
    if (cmd.set_found) begin
      hit <= (lo < count) && (rdata == key);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found    <= hit;
      position <= POS_W'(lo);
    end
  end

endmodule

/* design/sorted_table_binary_search_top.sv */
// a search loads the key, then for each bisection probe reads the middle entry and moves lo or hi,
// then reads the entry at lo, sets found, and loads the output register once it is free
// in_ready stays low from a search's acceptance until its result is loaded into the output register
// clear and append words give no result word
// a finished result waits in the output register while clear or append words go on
// reset clears the entry count and the output valid; table contents stay undefined
`timescale 1ns / 1ps

module sorted_table_binary_search_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stbs_pkg::REQ_W-1:0]         req_type,
  input  logic signed [stbs_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [stbs_pkg::POS_W-1:0]         position
);
  import stbs_pkg::*;

  stbs_cmd_t    cmd;
  stbs_status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position)
  );

endmodule

/* bench/stbs_search_checker.sv */
`timescale 1ns / 1ps

module stbs_search_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [stbs_pkg::REQ_W-1:0]          req_type,
  input  logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                found,
  input  logic [stbs_pkg::POS_W-1:0]          position,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_seen,
  output int                                  hits_seen
);

  import stbs_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
  int                        entry_count;
  search_result_t            pending_lookups [$];
  search_result_t            due;
  int                        mismatches;
  int                        checked;
  int                        hits;

  function automatic search_result_t lower_bound(input logic signed [VALUE_W-1:0] key);
    int             lo;
    int             hi;
    int             mid;
    search_result_t r;
    lo = 0;
    hi = entry_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    r.found = 1'b0;
    if (lo < entry_count) begin
      r.found = (table_copy[lo] == key);
    end
    r.position = POS_W'(lo);
    return r;
  endfunction

  initial begin
    entry_count = 0;
    mismatches  = 0;
    checked     = 0;
    hits        = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      entry_count = 0;
      pending_lookups.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t ns: result word with none due, expected nothing, actual found=%0b position=%0d",
                   $time, found, position);
          mismatches++;
        end else begin
          due = pending_lookups.pop_front();
          checked++;
          if (due.found) hits++;
          if (found !== due.found) begin
            $display("%0t ns: found mismatch, expected %0b actual %0b",
                     $time, due.found, found);
            mismatches++;
          end
          if (position !== due.position) begin
            $display("%0t ns: position mismatch, expected %0d actual %0d",
                     $time, due.position, position);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (req_type)
          REQ_CLEAR: entry_count = 0;
          REQ_APPEND: begin
            if (entry_count < TABLE_DEPTH) begin
              table_copy[entry_count] = value;
              entry_count++;
            end
          end
          REQ_SEARCH: pending_lookups.push_back(lower_bound(value));
          default: ;
        endcase
      end
    end
    fail_count   <= mismatches;
    pending      <= pending_lookups.size();
    results_seen <= checked;
    hits_seen    <= hits;
  end

endmodule

/* bench/sorted_table_binary_search_top_tb.sv */
`timescale 1ns / 1ps

module sorted_table_binary_search_top_tb;

  import stbs_pkg::*;

  localparam logic [REQ_W-1:0]          REQ_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN    = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
  localparam int                        WATCHDOG_LIMIT = 2000;
  localparam int                        RX_HOLD_CYCLES = 300;
  localparam int                        SETTLE_CYCLES  = 30;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [REQ_W-1:0]          req_type  = REQ_CLEAR;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      found;
  logic [POS_W-1:0]          position;

  int fail_count;
  int pending;
  int results_seen;
  int hits_seen;

  int tx_idle = 10;
  int rx_idle = 88;
  int rx_holds_asked = 0;
  int rx_holds_done = 0;
  int rx_hold_left = 0;
  int idle_cycles = 0;
  int words_sent = 0;

  logic signed [VALUE_W-1:0] stored [$];

  sorted_table_binary_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position)
  );

  stbs_search_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .position     (position),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_holds_asked != rx_holds_done) begin
      out_ready     <= 1'b0;
      rx_holds_done <= rx_holds_done + 1;
      rx_hold_left  <= RX_HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [REQ_W-1:0] rq, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    value    <= v;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    words_sent++;
    if (rq == REQ_CLEAR) stored.delete();
    else if (rq == REQ_APPEND && stored.size() < TABLE_DEPTH) stored.push_back(v);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_key();
    int     sel;
    int     idx;
    longint k;
    sel = $urandom_range(0, 99);
    if (stored.size() == 0 || sel < 20) return $urandom();
    idx = $urandom_range(0, stored.size() - 1);
    k = stored[idx];
    if (sel < 65) return stored[idx];
    if (sel >= 92) return sel[0] ? VAL_MAX : VAL_MIN;
    if (sel < 80) k = k + 1;
    else k = k - 1;
    if (k > longint'(VAL_MAX)) k = VAL_MAX;
    if (k < longint'(VAL_MIN)) k = VAL_MIN;
    return k[VALUE_W-1:0];
  endfunction

  // clear, ascending appends with the odd stray word, lookup or unused code, then lookups
  task automatic run_table_set(input int n_vals, input int n_keys);
    longint v;
    longint span;
    int     i;
    send_word(REQ_CLEAR, $urandom());
    case ($urandom_range(0, 3))
      0: begin
        v    = $signed($urandom());
        span = 3;
      end
      1: begin
        v    = $signed($urandom());
        span = 64'd1 << 26;
      end
      2: begin
        v    = VAL_MIN;
        span = 64'd6442450941 / (n_vals + 1);
      end
      default: begin
        v    = -longint'($urandom_range(0, 100));
        span = 20;
      end
    endcase
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    for (i = 0; i < n_vals; i++) begin
      if ($urandom_range(0, 99) < 3) send_word(REQ_UNUSED, $urandom());
      if ($urandom_range(0, 99) < 10) send_word(REQ_SEARCH, pick_key());
      if ($urandom_range(0, 99) < 4) begin
        send_word(REQ_APPEND, $urandom());
      end else begin
        send_word(REQ_APPEND, v[VALUE_W-1:0]);
        v = v + $urandom_range(0, span[31:0]);
        if (v > longint'(VAL_MAX)) v = VAL_MAX;
      end
    end
    for (i = 0; i < n_keys; i++) begin
      if ($urandom_range(0, 99) < 2) send_word(REQ_UNUSED, $urandom());
      send_word(REQ_SEARCH, pick_key());
    end
  endtask

  task automatic run_random_sets(input int stop_at);
    int n_vals;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) n_vals = $urandom_range(25, 120);
      else n_vals = $urandom_range(0, 24);
      run_table_set(n_vals, $urandom_range(1, 16));
      if ($urandom_range(0, 3) == 0) await_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicates, ignored code, unsorted contents
    send_word(REQ_SEARCH, 32'sd0);
    send_word(REQ_SEARCH, VAL_MIN);
    send_word(REQ_UNUSED, 32'shFFFF_FFFF);
    send_word(REQ_APPEND, VAL_MIN);
    send_word(REQ_APPEND, -32'sd5);
    send_word(REQ_APPEND, 32'sd0);
    send_word(REQ_APPEND, 32'sd0);
    send_word(REQ_APPEND, 32'sd7);
    send_word(REQ_APPEND, VAL_MAX);
    send_word(REQ_SEARCH, VAL_MIN);
    send_word(REQ_SEARCH, VAL_MAX);
    send_word(REQ_SEARCH, 32'sd0);
    send_word(REQ_SEARCH, 32'sd3);
    send_word(REQ_SEARCH, -32'sd6);
    send_word(REQ_UNUSED, 32'sd5);
    send_word(REQ_SEARCH, VAL_MAX - 32'sd1);
    send_word(REQ_CLEAR, 32'sd0);
    send_word(REQ_SEARCH, 32'sd0);
    send_word(REQ_APPEND, 32'sd50);
    send_word(REQ_APPEND, -32'sd9);
    send_word(REQ_APPEND, 32'sd30);
    send_word(REQ_SEARCH, 32'sd30);
    send_word(REQ_SEARCH, -32'sd9);
    send_word(REQ_CLEAR, 32'sd0);
    await_results();

    // receiver holds off while lookups keep coming
    rx_holds_asked++;
    run_table_set(6, 20);
    await_results();
    run_random_sets(150);
    await_results();

    tx_idle = 88;
    rx_idle = 10;
    run_random_sets(300);
    await_results();

    tx_idle = 0;
    rx_idle = 0;
    run_table_set(TABLE_DEPTH + 3, 40);
    await_results();
    run_random_sets(1550);

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d words: clear, append, lookup, unused codes, unsorted entries",
             words_sent);
    $display("checked %0d lookup results (%0d hits), table filled past full once",
             results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/stbs_pkg.sv
design/stbs_ctrl.sv
design/stbs_datapath.sv
design/sorted_table_binary_search_top.sv
bench/stbs_search_checker.sv
bench/sorted_table_binary_search_top_tb.sv
